/* sv/iamt_pkg.sv */
// Shared constants, codes and types of the identifier allocator with mask table.
package iamt_pkg;

    localparam int MAX_IDS   = 1024;
    localparam int MASK_BITS = 32;
    localparam int ID_W      = $clog2(MAX_IDS);
    localparam int CNT_W     = $clog2(MAX_IDS + 1);
    localparam int ENT_W     = 11;
    localparam int MASKIO_W  = 32;
    localparam int IDOUT_W   = 10;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_RANGE    = 2'd2,
        STAT_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    // Free list memory port request
    typedef struct packed {
        logic            wr_en;
        logic [ID_W-1:0] wr_addr;
        logic [ID_W-1:0] wr_data;
        logic            rd_en;
        logic [ID_W-1:0] rd_addr;
    } t_fl_req;

    // Mask table memory port request
    typedef struct packed {
        logic                 wr_en;
        logic [ID_W-1:0]      wr_addr;
        logic [MASK_BITS-1:0] wr_data;
        logic                 rd_en;
        logic [ID_W-1:0]      rd_addr;
    } t_mk_req;

    // Controller status seen by the top level
    typedef struct packed {
        logic             clearing;
        logic             stage_valid;
        logic [CNT_W-1:0] free_cnt;
        logic [CNT_W-1:0] alive_cnt;
    } t_ctrl_stat;

endpackage

/* sv/iamt_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module iamt_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port with registered read data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/iamt_ctrl.sv */
// Sequencer of the allocator: clearing pass, memory reads, read-modify-write and result register.
module iamt_ctrl
    import iamt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_opcode,
    input  logic [ENT_W-1:0]     i_entity_id,
    input  logic [MASKIO_W-1:0]  i_mask_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_status,
    output logic [IDOUT_W-1:0]   o_id_out,
    output logic [MASKIO_W-1:0]  o_mask_out,
    output logic [CNT_W-1:0]     o_living_count,
    output t_fl_req              o_fl_req,
    input  logic [ID_W-1:0]      i_fl_rd_data,
    output t_mk_req              o_mk_req,
    input  logic [MASK_BITS-1:0] i_mk_rd_data,
    output t_ctrl_stat           o_stat
);

    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_IDS);
    localparam logic [ID_W-1:0]  PTR_LAST = ID_W'(MAX_IDS - 1);

    t_state               r_state, n_state;
    logic [ID_W-1:0]      r_clr_addr, n_clr_addr;
    logic [ID_W-1:0]      r_head, n_head;
    logic [ID_W-1:0]      r_tail, n_tail;
    logic [CNT_W-1:0]     r_free_cnt, n_free_cnt;
    logic [CNT_W-1:0]     r_alive, n_alive;
    logic [CNT_W-1:0]     r_fill, n_fill;
    t_op                  r_op;
    logic [ID_W-1:0]      r_id;
    logic                 r_in_range;
    logic [MASK_BITS-1:0] r_mask;
    logic                 r_out_valid;
    t_status              r_status, n_status;
    logic [ID_W-1:0]      r_id_out, n_id_out;
    logic [MASK_BITS-1:0] r_mask_out, n_mask_out;
    logic [CNT_W-1:0]     r_living;

    logic accept;
    logic complete;

    assign accept   = (r_state == S_IDLE) && i_in_valid;
    assign complete = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    // State and bookkeeping registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_free_cnt <= CNT_MAX;
            r_alive    <= '0;
            r_fill     <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_free_cnt <= n_free_cnt;
            r_alive    <= n_alive;
            r_fill     <= n_fill;
        end
    end

    // Hold the accepted transaction while the memories are read
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= t_op'(i_opcode);
            r_id       <= ID_W'(i_entity_id);
            r_in_range <= (32'(i_entity_id) < MAX_IDS);
            r_mask     <= MASK_BITS'(i_mask_in);
        end
    end

    // Result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (complete) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (complete) begin
            r_status   <= n_status;
            r_id_out   <= n_id_out;
            r_mask_out <= n_mask_out;
            r_living   <= n_alive;
        end
    end

    // Next state, memory requests and result
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_head     = r_head;
        n_tail     = r_tail;
        n_free_cnt = r_free_cnt;
        n_alive    = r_alive;
        n_fill     = r_fill;
        n_status   = STAT_OK;
        n_id_out   = '0;
        n_mask_out = '0;

        o_fl_req.wr_en   = 1'b0;
        o_fl_req.wr_addr = r_tail;
        o_fl_req.wr_data = r_id;
        o_fl_req.rd_en   = accept;
        o_fl_req.rd_addr = r_head;

        o_mk_req.wr_en   = 1'b0;
        o_mk_req.wr_addr = r_id;
        o_mk_req.wr_data = '0;
        o_mk_req.rd_en   = accept;
        o_mk_req.rd_addr = ID_W'(i_entity_id);

        case (r_state)
            S_CLEAR: begin
                // Sweep the mask table to zero, one entry a cycle
                o_mk_req.wr_en   = 1'b1;
                o_mk_req.wr_addr = r_clr_addr;
                n_clr_addr       = r_clr_addr + 1'b1;
                if (r_clr_addr == PTR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_op == OP_ALLOC) begin
                    if (r_alive >= CNT_MAX || r_free_cnt == '0) begin
                        n_status = STAT_FULL;
                    end else begin
                        // Slots never pushed since reset still hold their own index
                        n_id_out   = (CNT_W'(r_head) < r_fill) ? i_fl_rd_data : r_head;
                        n_head     = (r_head == PTR_LAST) ? '0 : r_head + 1'b1;
                        n_free_cnt = r_free_cnt - 1'b1;
                        n_alive    = r_alive + 1'b1;
                    end
                end else if (!r_in_range) begin
                    n_status = STAT_RANGE;
                end else if (r_op == OP_FREE) begin
                    o_mk_req.wr_en = complete;
                    if (r_free_cnt >= CNT_MAX) begin
                        n_status = STAT_OVERFLOW;
                    end else begin
                        o_fl_req.wr_en = complete;
                        n_tail         = (r_tail == PTR_LAST) ? '0 : r_tail + 1'b1;
                        n_free_cnt     = r_free_cnt + 1'b1;
                        n_fill         = (r_fill < CNT_MAX) ? r_fill + 1'b1 : r_fill;
                    end
                    if (r_alive != '0) begin
                        n_alive = r_alive - 1'b1;
                    end
                end else if (r_op == OP_WRITE) begin
                    o_mk_req.wr_en   = complete;
                    o_mk_req.wr_data = r_mask;
                end else begin
                    n_mask_out = i_mk_rd_data;
                end

                // Drop the bookkeeping update while the result register is blocked
                if (!complete) begin
                    n_head     = r_head;
                    n_tail     = r_tail;
                    n_free_cnt = r_free_cnt;
                    n_fill     = r_fill;
                    n_alive    = r_alive;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_id_out       = IDOUT_W'(r_id_out);
    assign o_mask_out     = MASKIO_W'(r_mask_out);
    assign o_living_count = r_living;

    assign o_stat.clearing    = (r_state == S_CLEAR);
    assign o_stat.stage_valid = (r_state == S_EXEC);
    assign o_stat.free_cnt    = r_free_cnt;
    assign o_stat.alive_cnt   = r_alive;

endmodule

/* sv/id_allocator_with_mask_table.sv */
// Top level of the identifier allocator: controller, free list memory and mask table memory.
//
// Input channel (i_in_valid / o_in_ready) carries one operation per transaction:
// allocate, free, write mask or read mask, with an identifier and a mask.
// Output channel (o_out_valid / i_out_ready) returns exactly one result per
// transaction: status, allocated identifier, mask read and the living count.
// Result path: the free list and the mask table are synchronous memories read
// at acceptance; their data is used in the execute state, where the result is
// registered and the memories written back once the output register is free.
// One operation in flight: the next transaction is taken only after the previous
// one leaves the execute state, set by the read then write-back sequence.
// Reset: the free list starts full with identifiers in ascending order (slots
// never pushed since reset read as their own index through a fill count), and
// the mask table is cleared by a pass over all 1024 entries during which
// o_in_ready stays low.
// Receiver stall: a result waits in the output register; the block still takes
// the next transaction and holds it until the output register frees up.
module id_allocator_with_mask_table
    import iamt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_opcode,
    input  logic [ENT_W-1:0]    i_entity_id,
    input  logic [MASKIO_W-1:0] i_mask_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_status,
    output logic [IDOUT_W-1:0]  o_id_out,
    output logic [MASKIO_W-1:0] o_mask_out,
    output logic [CNT_W-1:0]    o_living_count
);

    t_fl_req              fl_req;
    t_mk_req              mk_req;
    logic [ID_W-1:0]      fl_rd_data;
    logic [MASK_BITS-1:0] mk_rd_data;
    t_ctrl_stat           stat;

    // Sequencer
    iamt_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_entity_id    (i_entity_id),
        .i_mask_in      (i_mask_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_id_out       (o_id_out),
        .o_mask_out     (o_mask_out),
        .o_living_count (o_living_count),
        .o_fl_req       (fl_req),
        .i_fl_rd_data   (fl_rd_data),
        .o_mk_req       (mk_req),
        .i_mk_rd_data   (mk_rd_data),
        .o_stat         (stat)
    );

    // Free list storage
    iamt_ram #(
        .DEPTH (MAX_IDS),
        .WIDTH (ID_W)
    ) u_fl_ram (
        .i_clk     (i_clk),
        .i_wr_en   (fl_req.wr_en),
        .i_wr_addr (fl_req.wr_addr),
        .i_wr_data (fl_req.wr_data),
        .i_rd_en   (fl_req.rd_en),
        .i_rd_addr (fl_req.rd_addr),
        .o_rd_data (fl_rd_data)
    );

    // Mask table storage
    iamt_ram #(
        .DEPTH (MAX_IDS),
        .WIDTH (MASK_BITS)
    ) u_mk_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mk_req.wr_en),
        .i_wr_addr (mk_req.wr_addr),
        .i_wr_data (mk_req.wr_data),
        .i_rd_en   (mk_req.rd_en),
        .i_rd_addr (mk_req.rd_addr),
        .o_rd_data (mk_rd_data)
    );

    // No transaction is taken while the mask table is being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.clearing |-> !o_in_ready)
        else $error("transaction taken during clearing pass");

    // A taken transaction occupies the execute stage on the next cycle
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> stat.stage_valid)
        else $error("accepted transaction lost");

    // Free and living counts each never exceed the identifier range
    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stat.free_cnt <= CNT_W'(MAX_IDS)) && (stat.alive_cnt <= CNT_W'(MAX_IDS)))
        else $error("count beyond identifier range");

    // A result with OK status and a zero living count carries identifier zero
    a_alloc_living: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STAT_OK && o_living_count == '0) |->
        (o_id_out == '0))
        else $error("living count zero after successful allocation");

endmodule
